// ===== hw/rtl/aes_pkg.sv =====
// ----------------------------------------------------------------------------
// aes_pkg: shared types, tables and byte functions
// Holds the S-box, the round constants and the round transformations used by
// the key expansion and the round cells.
// ----------------------------------------------------------------------------
package aes_pkg;

   localparam int unsigned NumRounds = 10;
   localparam int unsigned RoundIdxWidth = 4;

   localparam logic [0:0] CsrKeyHigh = 1'b0;
   localparam logic [0:0] CsrKeyLow  = 1'b1;

   typedef logic [127:0] block_type;

   // data handed from one round cell to the next
   typedef struct packed {
      logic      valid;
      block_type state;
   } stage_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] r;
      begin
         unique case (a)
            8'h00: r = 8'h63; 8'h01: r = 8'h7c; 8'h02: r = 8'h77; 8'h03: r = 8'h7b;
            8'h04: r = 8'hf2; 8'h05: r = 8'h6b; 8'h06: r = 8'h6f; 8'h07: r = 8'hc5;
            8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0a: r = 8'h67; 8'h0b: r = 8'h2b;
            8'h0c: r = 8'hfe; 8'h0d: r = 8'hd7; 8'h0e: r = 8'hab; 8'h0f: r = 8'h76;
            8'h10: r = 8'hca; 8'h11: r = 8'h82; 8'h12: r = 8'hc9; 8'h13: r = 8'h7d;
            8'h14: r = 8'hfa; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hf0;
            8'h18: r = 8'had; 8'h19: r = 8'hd4; 8'h1a: r = 8'ha2; 8'h1b: r = 8'haf;
            8'h1c: r = 8'h9c; 8'h1d: r = 8'ha4; 8'h1e: r = 8'h72; 8'h1f: r = 8'hc0;
            8'h20: r = 8'hb7; 8'h21: r = 8'hfd; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
            8'h24: r = 8'h36; 8'h25: r = 8'h3f; 8'h26: r = 8'hf7; 8'h27: r = 8'hcc;
            8'h28: r = 8'h34; 8'h29: r = 8'ha5; 8'h2a: r = 8'he5; 8'h2b: r = 8'hf1;
            8'h2c: r = 8'h71; 8'h2d: r = 8'hd8; 8'h2e: r = 8'h31; 8'h2f: r = 8'h15;
            8'h30: r = 8'h04; 8'h31: r = 8'hc7; 8'h32: r = 8'h23; 8'h33: r = 8'hc3;
            8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9a;
            8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3a: r = 8'h80; 8'h3b: r = 8'he2;
            8'h3c: r = 8'heb; 8'h3d: r = 8'h27; 8'h3e: r = 8'hb2; 8'h3f: r = 8'h75;
            8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2c; 8'h43: r = 8'h1a;
            8'h44: r = 8'h1b; 8'h45: r = 8'h6e; 8'h46: r = 8'h5a; 8'h47: r = 8'ha0;
            8'h48: r = 8'h52; 8'h49: r = 8'h3b; 8'h4a: r = 8'hd6; 8'h4b: r = 8'hb3;
            8'h4c: r = 8'h29; 8'h4d: r = 8'he3; 8'h4e: r = 8'h2f; 8'h4f: r = 8'h84;
            8'h50: r = 8'h53; 8'h51: r = 8'hd1; 8'h52: r = 8'h00; 8'h53: r = 8'hed;
            8'h54: r = 8'h20; 8'h55: r = 8'hfc; 8'h56: r = 8'hb1; 8'h57: r = 8'h5b;
            8'h58: r = 8'h6a; 8'h59: r = 8'hcb; 8'h5a: r = 8'hbe; 8'h5b: r = 8'h39;
            8'h5c: r = 8'h4a; 8'h5d: r = 8'h4c; 8'h5e: r = 8'h58; 8'h5f: r = 8'hcf;
            8'h60: r = 8'hd0; 8'h61: r = 8'hef; 8'h62: r = 8'haa; 8'h63: r = 8'hfb;
            8'h64: r = 8'h43; 8'h65: r = 8'h4d; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
            8'h68: r = 8'h45; 8'h69: r = 8'hf9; 8'h6a: r = 8'h02; 8'h6b: r = 8'h7f;
            8'h6c: r = 8'h50; 8'h6d: r = 8'h3c; 8'h6e: r = 8'h9f; 8'h6f: r = 8'ha8;
            8'h70: r = 8'h51; 8'h71: r = 8'ha3; 8'h72: r = 8'h40; 8'h73: r = 8'h8f;
            8'h74: r = 8'h92; 8'h75: r = 8'h9d; 8'h76: r = 8'h38; 8'h77: r = 8'hf5;
            8'h78: r = 8'hbc; 8'h79: r = 8'hb6; 8'h7a: r = 8'hda; 8'h7b: r = 8'h21;
            8'h7c: r = 8'h10; 8'h7d: r = 8'hff; 8'h7e: r = 8'hf3; 8'h7f: r = 8'hd2;
            8'h80: r = 8'hcd; 8'h81: r = 8'h0c; 8'h82: r = 8'h13; 8'h83: r = 8'hec;
            8'h84: r = 8'h5f; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
            8'h88: r = 8'hc4; 8'h89: r = 8'ha7; 8'h8a: r = 8'h7e; 8'h8b: r = 8'h3d;
            8'h8c: r = 8'h64; 8'h8d: r = 8'h5d; 8'h8e: r = 8'h19; 8'h8f: r = 8'h73;
            8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4f; 8'h93: r = 8'hdc;
            8'h94: r = 8'h22; 8'h95: r = 8'h2a; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
            8'h98: r = 8'h46; 8'h99: r = 8'hee; 8'h9a: r = 8'hb8; 8'h9b: r = 8'h14;
            8'h9c: r = 8'hde; 8'h9d: r = 8'h5e; 8'h9e: r = 8'h0b; 8'h9f: r = 8'hdb;
            8'ha0: r = 8'he0; 8'ha1: r = 8'h32; 8'ha2: r = 8'h3a; 8'ha3: r = 8'h0a;
            8'ha4: r = 8'h49; 8'ha5: r = 8'h06; 8'ha6: r = 8'h24; 8'ha7: r = 8'h5c;
            8'ha8: r = 8'hc2; 8'ha9: r = 8'hd3; 8'haa: r = 8'hac; 8'hab: r = 8'h62;
            8'hac: r = 8'h91; 8'had: r = 8'h95; 8'hae: r = 8'he4; 8'haf: r = 8'h79;
            8'hb0: r = 8'he7; 8'hb1: r = 8'hc8; 8'hb2: r = 8'h37; 8'hb3: r = 8'h6d;
            8'hb4: r = 8'h8d; 8'hb5: r = 8'hd5; 8'hb6: r = 8'h4e; 8'hb7: r = 8'ha9;
            8'hb8: r = 8'h6c; 8'hb9: r = 8'h56; 8'hba: r = 8'hf4; 8'hbb: r = 8'hea;
            8'hbc: r = 8'h65; 8'hbd: r = 8'h7a; 8'hbe: r = 8'hae; 8'hbf: r = 8'h08;
            8'hc0: r = 8'hba; 8'hc1: r = 8'h78; 8'hc2: r = 8'h25; 8'hc3: r = 8'h2e;
            8'hc4: r = 8'h1c; 8'hc5: r = 8'ha6; 8'hc6: r = 8'hb4; 8'hc7: r = 8'hc6;
            8'hc8: r = 8'he8; 8'hc9: r = 8'hdd; 8'hca: r = 8'h74; 8'hcb: r = 8'h1f;
            8'hcc: r = 8'h4b; 8'hcd: r = 8'hbd; 8'hce: r = 8'h8b; 8'hcf: r = 8'h8a;
            8'hd0: r = 8'h70; 8'hd1: r = 8'h3e; 8'hd2: r = 8'hb5; 8'hd3: r = 8'h66;
            8'hd4: r = 8'h48; 8'hd5: r = 8'h03; 8'hd6: r = 8'hf6; 8'hd7: r = 8'h0e;
            8'hd8: r = 8'h61; 8'hd9: r = 8'h35; 8'hda: r = 8'h57; 8'hdb: r = 8'hb9;
            8'hdc: r = 8'h86; 8'hdd: r = 8'hc1; 8'hde: r = 8'h1d; 8'hdf: r = 8'h9e;
            8'he0: r = 8'he1; 8'he1: r = 8'hf8; 8'he2: r = 8'h98; 8'he3: r = 8'h11;
            8'he4: r = 8'h69; 8'he5: r = 8'hd9; 8'he6: r = 8'h8e; 8'he7: r = 8'h94;
            8'he8: r = 8'h9b; 8'he9: r = 8'h1e; 8'hea: r = 8'h87; 8'heb: r = 8'he9;
            8'hec: r = 8'hce; 8'hed: r = 8'h55; 8'hee: r = 8'h28; 8'hef: r = 8'hdf;
            8'hf0: r = 8'h8c; 8'hf1: r = 8'ha1; 8'hf2: r = 8'h89; 8'hf3: r = 8'h0d;
            8'hf4: r = 8'hbf; 8'hf5: r = 8'he6; 8'hf6: r = 8'h42; 8'hf7: r = 8'h68;
            8'hf8: r = 8'h41; 8'hf9: r = 8'h99; 8'hfa: r = 8'h2d; 8'hfb: r = 8'h0f;
            8'hfc: r = 8'hb0; 8'hfd: r = 8'h54; 8'hfe: r = 8'hbb; 8'hff: r = 8'h16;
            default: r = 8'h00;
         endcase
         return r;
      end
   endfunction

   // round constant for round 1..10
   function automatic logic [7:0] rcon(input logic [RoundIdxWidth-1:0] rnd);
      logic [7:0] r;
      begin
         unique case (rnd)
            4'd1:  r = 8'h01;
            4'd2:  r = 8'h02;
            4'd3:  r = 8'h04;
            4'd4:  r = 8'h08;
            4'd5:  r = 8'h10;
            4'd6:  r = 8'h20;
            4'd7:  r = 8'h40;
            4'd8:  r = 8'h80;
            4'd9:  r = 8'h1b;
            4'd10: r = 8'h36;
            default: r = 8'h00;
         endcase
         return r;
      end
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of the block, byte 0 most significant
   function automatic logic [7:0] get_byte(input block_type b, input int unsigned i);
      return b[127 - 8*i -: 8];
   endfunction

   // subbytes then shiftrows
   function automatic block_type sub_shift(input block_type st);
      block_type r;
      begin
         r = '0;
         for (int c = 0; c < 4; c++) begin
            for (int rw = 0; rw < 4; rw++) begin
               r[127 - 8*(c*4 + rw) -: 8] = sbox(get_byte(st, ((c + rw) % 4)*4 + rw));
            end
         end
         return r;
      end
   endfunction

   function automatic block_type mix(input block_type st);
      block_type r;
      logic [7:0] a0, a1, a2, a3;
      begin
         r = '0;
         for (int c = 0; c < 4; c++) begin
            a0 = get_byte(st, c*4);
            a1 = get_byte(st, c*4 + 1);
            a2 = get_byte(st, c*4 + 2);
            a3 = get_byte(st, c*4 + 3);
            r[127 - 8*(c*4)     -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            r[127 - 8*(c*4 + 1) -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            r[127 - 8*(c*4 + 2) -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            r[127 - 8*(c*4 + 3) -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
         end
         return r;
      end
   endfunction

   // next round key from the previous one
   function automatic block_type next_key(input block_type k,
                                          input logic [RoundIdxWidth-1:0] rnd);
      logic [31:0] w0, w1, w2, w3, t;
      begin
         w0 = k[127:96];
         w1 = k[95:64];
         w2 = k[63:32];
         w3 = k[31:0];
         t  = {sbox(w3[23:16]) ^ rcon(rnd), sbox(w3[15:8]), sbox(w3[7:0]),
               sbox(w3[31:24])};
         w0 = w0 ^ t;
         w1 = w1 ^ w0;
         w2 = w2 ^ w1;
         w3 = w3 ^ w2;
         return {w0, w1, w2, w3};
      end
   endfunction

endpackage

// ===== hw/rtl/aes_round_cell.sv =====
// ----------------------------------------------------------------------------
// aes_round_cell: one round of the cipher chain
// Applies one round to the state and derives the next round key, then hands
// both to the following cell. The last cell skips mixcolumns.
// ----------------------------------------------------------------------------
module aes_round_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic [aes_pkg::RoundIdxWidth-1:0]   round_idx,
   input  aes_pkg::stage_type                   stage_prev,
   input  aes_pkg::block_type                   key_prev,
   output aes_pkg::stage_type                   stage_next,
   output aes_pkg::block_type                   key_next
);
   import aes_pkg::*;

   logic      valid_ff;
   block_type state_ff, state_in;
   block_type key_ff, key_in;
   block_type shifted;

   // round datapath
   always_comb begin
      key_in  = next_key(key_prev, round_idx);
      shifted = sub_shift(stage_prev.state);
      if (round_idx == RoundIdxWidth'(NumRounds)) begin
         state_in = shifted ^ key_in;
      end else begin
         state_in = mix(shifted) ^ key_in;
      end
   end

   // cell registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= stage_prev.valid;
      end
      if (advance) begin
         state_ff <= state_in;
         key_ff   <= key_in;
      end
   end

   assign stage_next = '{valid: valid_ff, state: state_ff};
   assign key_next   = key_ff;

endmodule

// ===== hw/rtl/aes128_block_encrypt.sv =====
// ----------------------------------------------------------------------------
// aes128_block_encrypt: pipelined AES-128 encryption
// Eleven-cell chain (initial key addition and ten rounds) accepting one block
// per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// A block accepted on req_ leaves on rsp_ after passing through the chain of
// eleven registered cells; while rsp_ready is held high, one block enters
// and one leaves every cycle. The cells are the key addition cell and one
// cell per round, each carrying its round key alongside the state. The key
// registers are sampled when a block is accepted, so the key may be changed
// between blocks. A stall on rsp_ freezes the whole chain.
module aes128_block_encrypt (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_plain_high,
   input  logic [63:0] req_plain_low,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_cipher_high,
   output logic [63:0] rsp_cipher_low,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [63:0] csr_data
);
   import aes_pkg::*;

   logic [63:0] key_high_ff, key_low_ff;
   logic        advance;
   logic        valid0_ff;
   block_type   state0_ff, key0_ff;
   stage_type   stage [0:NumRounds];
   block_type   rkey  [0:NumRounds];

   assign csr_ready = 1'b1;

   // key registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CsrKeyHigh: key_high_ff <= csr_data;
            CsrKeyLow:  key_low_ff  <= csr_data;
            default:    key_high_ff <= key_high_ff;
         endcase
      end
   end

   // chain moves whenever the output slot is empty or being drained
   assign advance   = !stage[NumRounds].valid || rsp_ready;
   assign req_ready = advance;

   // initial key addition cell
   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
      end else if (advance) begin
         valid0_ff <= req_valid;
      end
      if (advance) begin
         state0_ff <= {req_plain_high, req_plain_low} ^ {key_high_ff, key_low_ff};
         key0_ff   <= {key_high_ff, key_low_ff};
      end
   end

   assign stage[0] = '{valid: valid0_ff, state: state0_ff};
   assign rkey[0]  = key0_ff;

   // round cells
   for (genvar g = 1; g <= NumRounds; g++) begin : g_round
      aes_round_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .round_idx  (RoundIdxWidth'(g)),
         .stage_prev (stage[g-1]),
         .key_prev   (rkey[g-1]),
         .stage_next (stage[g]),
         .key_next   (rkey[g])
      );
   end

   assign rsp_valid       = stage[NumRounds].valid;
   assign rsp_cipher_high = stage[NumRounds].state[127:64];
   assign rsp_cipher_low  = stage[NumRounds].state[63:0];

   // a stalled result holds its value
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cipher_high)
                                   && $stable(rsp_cipher_low))
      else $error("result changed while stalled");

   // input is taken exactly when the chain advances
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("ready does not follow chain advance");

   // an accepted block reaches the first cell
   a_entry: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> stage[0].valid)
      else $error("accepted transaction lost at entry");

endmodule

// ===== verif/tb_aes128_block_encrypt.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_aes128_block_encrypt: self-checking bench for the AES-128 pipeline
// Drives plaintext blocks under several keys, predicts each ciphertext with a
// behavioural AES-128 written here, and compares every response in order.
// Both sides idle at random in the first two of three phases; neither idles in
// the third. Keys change only when idle.
module tb_aes128_block_encrypt;
   import aes_pkg::*;

   typedef struct packed {
      logic [63:0] hi;
      logic [63:0] lo;
   } blk_t;

   typedef struct {
      bit          is_key;
      logic [0:0]  idx;
      logic [63:0] data;
      blk_t        blk;
      bit          drain;
   } job_t;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [63:0] req_plain_high;
   logic [63:0] req_plain_low;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [63:0] rsp_cipher_high;
   logic [63:0] rsp_cipher_low;
   logic        csr_valid;
   logic        csr_ready;
   logic [0:0]  csr_index;
   logic [63:0] csr_data;

   job_t  job_q[$];
   blk_t  cipher_q[$];
   logic [63:0] key_hi_m, key_lo_m;
   int    send_idle_pct, recv_idle_pct;
   int    n_errors;
   bit    stim_done;
   int    drain_wait;
   bit    req_acc, csr_acc;

   aes128_block_encrypt dut (.*);

   // clock
   always begin
      clock = 1'b1; #4;
      clock = 1'b0; #4;
   end

   // byte-level AES tables and helpers
   byte unsigned sb[256];
   byte unsigned rc[10] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
                            8'h1b, 8'h36};

   function automatic byte unsigned gmul2(byte unsigned a);
      return byte'((a << 1) ^ ((a & 8'h80) != 0 ? 8'h1b : 8'h00));
   endfunction

   // fill the s-box from the multiplicative inverse and affine map
   initial begin
      byte unsigned inv, b, x;
      for (int i = 0; i < 256; i++) begin
         inv = 0;
         for (int j = 1; j < 256; j++) begin
            byte unsigned p, aa, bb;
            p = 0; aa = i; bb = j;
            for (int k = 0; k < 8; k++) begin
               if (bb & 1) p ^= aa;
               aa = gmul2(aa);
               bb >>= 1;
            end
            if (p == 1) inv = j;
         end
         b = inv; x = inv;
         for (int k = 0; k < 4; k++) begin
            b = {b[6:0], b[7]};
            x ^= b;
         end
         sb[i] = x ^ 8'h63;
      end
   end

   function automatic blk_t encrypt(logic [63:0] kh, logic [63:0] kl, blk_t pt);
      byte unsigned rk[176];
      byte unsigned st[16];
      byte unsigned tmp[16];
      byte unsigned t[4];
      byte unsigned s, a0, a1, a2, a3;
      blk_t r;
      for (int i = 0; i < 8; i++) begin
         rk[i]     = kh[63-8*i -: 8];
         rk[8 + i] = kl[63-8*i -: 8];
         st[i]     = pt.hi[63-8*i -: 8];
         st[8 + i] = pt.lo[63-8*i -: 8];
      end
      // key schedule
      for (int n = 16; n < 176; n += 4) begin
         for (int i = 0; i < 4; i++) t[i] = rk[n - 4 + i];
         if (n % 16 == 0) begin
            s = t[0];
            t[0] = sb[t[1]] ^ rc[n/16 - 1];
            t[1] = sb[t[2]];
            t[2] = sb[t[3]];
            t[3] = sb[s];
         end
         for (int i = 0; i < 4; i++) rk[n + i] = rk[n - 16 + i] ^ t[i];
      end
      for (int i = 0; i < 16; i++) st[i] ^= rk[i];
      // rounds
      for (int rnd = 1; rnd <= 10; rnd++) begin
         for (int c = 0; c < 4; c++)
            for (int w = 0; w < 4; w++)
               tmp[c*4 + w] = sb[st[((c + w) % 4)*4 + w]];
         st = tmp;
         if (rnd < 10) begin
            for (int c = 0; c < 4; c++) begin
               a0 = st[c*4]; a1 = st[c*4+1]; a2 = st[c*4+2]; a3 = st[c*4+3];
               st[c*4]   = gmul2(a0) ^ gmul2(a1) ^ a1 ^ a2 ^ a3;
               st[c*4+1] = a0 ^ gmul2(a1) ^ gmul2(a2) ^ a2 ^ a3;
               st[c*4+2] = a0 ^ a1 ^ gmul2(a2) ^ gmul2(a3) ^ a3;
               st[c*4+3] = gmul2(a0) ^ a0 ^ a1 ^ a2 ^ gmul2(a3);
            end
         end
         for (int i = 0; i < 16; i++) st[i] ^= rk[rnd*16 + i];
      end
      for (int i = 0; i < 8; i++) begin
         r.hi[63-8*i -: 8] = st[i];
         r.lo[63-8*i -: 8] = st[8 + i];
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      n_errors++;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // random field with frequent extremes and sparse patterns
   function automatic logic [63:0] field64();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return 64'h1 << $urandom_range(0, 63);
         default: return rand64();
      endcase
   endfunction

   task automatic push_key(logic [0:0] idx, logic [63:0] d);
      job_t j;
      j = '{default: '0};
      j.is_key = 1; j.idx = idx; j.data = d;
      job_q.push_back(j);
   endtask

   task automatic push_blk(logic [63:0] h, logic [63:0] l);
      job_t j;
      j = '{default: '0};
      j.blk = '{hi: h, lo: l};
      job_q.push_back(j);
   endtask

   task automatic push_drain();
      job_t j;
      j = '{default: '0};
      j.drain = 1;
      job_q.push_back(j);
   endtask

   // driver: key writes wait for an empty pipeline, blocks stream
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         if ((req_valid && !req_acc) || (csr_valid && !csr_acc)) begin
            // hold current transaction
         end else begin
            bit go;
            go = 0;
            if (job_q.size() != 0) begin
               if (job_q[0].is_key || job_q[0].drain) begin
                  go = (cipher_q.size() == 0 && drain_wait >= 14);
               end else begin
                  go = ($urandom_range(0, 99) >= send_idle_pct);
               end
            end
            if (go && job_q[0].drain) begin
               void'(job_q.pop_front());
               go = 0;
            end
            if (go && job_q[0].is_key) begin
               csr_valid <= 1'b1;
               csr_index <= job_q[0].idx;
               csr_data  <= job_q[0].data;
               req_valid <= 1'b0;
               void'(job_q.pop_front());
            end else if (go) begin
               req_valid      <= 1'b1;
               req_plain_high <= job_q[0].blk.hi;
               req_plain_low  <= job_q[0].blk.lo;
               csr_valid      <= 1'b0;
               void'(job_q.pop_front());
            end else begin
               req_valid <= 1'b0;
               csr_valid <= 1'b0;
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         drain_wait <= (cipher_q.size() == 0) ? drain_wait + 1 : 0;
      end
   end

   // record accepted transactions at the clock edge they happen
   always @(posedge clock) begin
      req_acc = !reset && req_valid && req_ready;
      csr_acc = !reset && csr_valid && csr_ready;
      if (req_acc) begin
         cipher_q.push_back(encrypt(key_hi_m, key_lo_m,
                                    '{hi: req_plain_high, lo: req_plain_low}));
      end
      if (csr_acc) begin
         if (csr_index == CsrKeyHigh) key_hi_m = csr_data;
         else key_lo_m = csr_data;
      end
   end

   // monitor: compare each response with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (cipher_q.size() == 0) begin
            $display("unexpected response %h %h", rsp_cipher_high, rsp_cipher_low);
            n_errors++;
         end else begin
            blk_t want;
            want = cipher_q.pop_front();
            if (rsp_cipher_high !== want.hi)
               report_mismatch("cipher_high", rsp_cipher_high, want.hi);
            if (rsp_cipher_low !== want.lo)
               report_mismatch("cipher_low", rsp_cipher_low, want.lo);
         end
      end
   end

   // stimulus
   initial begin
      reset = 1'b1;
      req_valid = 0; req_plain_high = 0; req_plain_low = 0;
      rsp_ready = 0; csr_valid = 0; csr_index = 0; csr_data = 0;
      key_hi_m = 0; key_lo_m = 0;
      n_errors = 0; stim_done = 0; drain_wait = 0;
      req_acc = 0; csr_acc = 0;
      send_idle_pct = 9; recv_idle_pct = 76;

      // zero key straight after reset
      push_blk('0, '0);
      push_blk('1, '1);
      push_blk(64'h0011223344556677, 64'h8899aabbccddeeff);
      push_blk(64'h8000000000000000, 64'h0000000000000001);
      // standard vector key
      push_key(CsrKeyHigh, 64'h0001020304050607);
      push_key(CsrKeyLow, 64'h08090a0b0c0d0e0f);
      push_blk(64'h0011223344556677, 64'h8899aabbccddeeff);
      push_blk('0, '1);
      push_blk('1, '0);
      push_drain();
      // all-ones key
      push_key(CsrKeyHigh, '1);
      push_key(CsrKeyLow, '1);
      push_blk('0, '0);
      push_blk('1, '1);
      push_blk(64'h3243f6a8885a308d, 64'h313198a2e0370734);
      // classic example key
      push_key(CsrKeyHigh, 64'h2b7e151628aed2a6);
      push_key(CsrKeyLow, 64'habf7158809cf4f3c);
      push_blk(64'h3243f6a8885a308d, 64'h313198a2e0370734);
      for (int i = 0; i < 6; i++) push_blk(field64(), field64());

      for (int ph = 0; ph < 3; ph++) begin
         for (int s = 0; s < 5; s++) begin
            push_key(CsrKeyHigh, field64());
            push_key(CsrKeyLow, field64());
            for (int i = 0; i < 100; i++) push_blk(field64(), field64());
            if (s == 2) push_drain();
         end
         push_drain();
         // wait for this phase to go through, then change idling
         repeat (12) @(posedge clock);
         reset = 1'b0;
         wait (job_q.size() == 0 && cipher_q.size() == 0);
         if (ph == 0) begin
            send_idle_pct = 76; recv_idle_pct = 9;
         end else begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end
      end
      stim_done = 1;
      repeat (30) @(posedge clock);
      if (cipher_q.size() != 0) begin
         $display("%0d responses missing", cipher_q.size());
         n_errors++;
      end
      if (n_errors == 0)
         $display("tb_aes128_block_encrypt: done, clean");
      else
         $display("tb_aes128_block_encrypt: done, errors");
      $finish;
   end

   // watchdog
   initial begin
      #2000000;
      $display("tb_aes128_block_encrypt: done, errors");
      $finish;
   end

endmodule
